/* design/xcfv_pkg.sv */
// ----------------------------------------------------------------------------
// xcfv_pkg
// Types and constants shared by the frame validator modules.
// ----------------------------------------------------------------------------
package xcfv_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 256;
    localparam int WIN_DEPTH           = 5;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 9;

    localparam logic [31:0] SUM_BIAS = 32'h0000_00AA;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LEN    = 3'd4;

    localparam logic [7:0] HEADER_RST     = 8'd0;
    localparam logic [7:0] FOOTER_RST     = 8'd0;
    localparam logic [7:0] UPDATE_THR_RST = 8'd0;
    localparam logic [8:0] SHORT_LEN_RST  = 9'd5;
    localparam logic [8:0] LONG_LEN_RST   = 9'd256;

    typedef enum logic [2:0] {
        VERDICT_SHORT_HOST   = 3'd0,
        VERDICT_LONG_HOST    = 3'd1,
        VERDICT_UNKNOWN_HOST = 3'd2,
        VERDICT_UPDATE       = 3'd3,
        VERDICT_FRAMING_ERR  = 3'd4,
        VERDICT_SUM_MISMATCH = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [7:0]  command_value;
        logic [8:0]  frame_length;
        logic [31:0] computed_sum;
    } t_out_item;

    typedef struct packed {
        logic [7:0] header_value;
        logic [7:0] footer_value;
        logic [7:0] update_command_threshold;
        logic [8:0] short_host_length;
        logic [8:0] long_host_length;
    } t_cfg;

endpackage

/* design/xcfv_frame_core.sv */
// ----------------------------------------------------------------------------
// xcfv_frame_core
// Per-frame state: byte count, trailer window, payload word XOR and the
// verdict for the byte being transferred.
// ----------------------------------------------------------------------------
module xcfv_frame_core #(
    parameter int MAX_FRAME_BYTES = xcfv_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  xcfv_pkg::t_in_item  i_in,
    input  xcfv_pkg::t_cfg      i_cfg,
    output xcfv_pkg::t_out_item o_result
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int EXT_W = POS_W + 9;
    localparam int WD    = xcfv_pkg::WIN_DEPTH;

    logic [POS_W-1:0] r_pos,     n_pos;
    logic [31:0]      r_acc,     n_acc;
    logic [23:0]      r_partial, n_partial;
    logic             r_hdr,     n_hdr;
    logic [7:0]       r_cmd,     n_cmd;
    logic [7:0]       r_win [WD];
    logic [7:0]       n_win [WD];

    logic             take;
    logic [1:0]       lane;
    logic [7:0]       tail;
    logic [31:0]      sum;
    logic [31:0]      rx_sum;
    logic [EXT_W-1:0] len_x;

    always_comb begin
        take      = r_pos <= POS_W'(MAX_FRAME_BYTES);
        lane      = r_pos[1:0] + 2'd3;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_partial = r_partial;
        n_hdr     = r_hdr;
        n_cmd     = r_cmd;
        for (int k = 0; k < WD; k++) begin
            n_win[k] = r_win[k];
        end
        if (take) begin
            if (r_pos == '0) begin
                n_hdr = i_in.rx_byte == i_cfg.header_value;
            end
            if (r_pos == POS_W'(1)) begin
                n_cmd = i_in.rx_byte;
            end
            if (r_pos >= POS_W'(WD)) begin
                case (lane)
                    2'd0: n_partial[7:0]   = r_win[0];
                    2'd1: n_partial[15:8]  = r_win[0];
                    2'd2: n_partial[23:16] = r_win[0];
                    default: begin
                        n_acc     = r_acc ^ {r_win[0], r_partial};
                        n_partial = '0;
                    end
                endcase
            end
            for (int k = 0; k < WD - 1; k++) begin
                n_win[k] = r_win[k+1];
            end
            n_win[WD-1] = i_in.rx_byte;
            n_pos       = r_pos + POS_W'(1);
        end

        tail   = n_partial[7:0] ^ n_partial[15:8] ^ n_partial[23:16];
        sum    = (n_acc ^ {24'd0, tail}) + xcfv_pkg::SUM_BIAS;
        rx_sum = {n_win[3], n_win[2], n_win[1], n_win[0]};
        len_x  = EXT_W'(n_pos);

        o_result.command_value = n_cmd;
        o_result.frame_length  = len_x[8:0];
        o_result.computed_sum  = sum;
        if (n_pos < POS_W'(WD)) begin
            o_result.verdict = xcfv_pkg::VERDICT_FRAMING_ERR;
        end else if (n_pos > POS_W'(MAX_FRAME_BYTES)) begin
            o_result.verdict      = xcfv_pkg::VERDICT_FRAMING_ERR;
            o_result.computed_sum = '0;
        end else if (!n_hdr || n_win[WD-1] != i_cfg.footer_value) begin
            o_result.verdict = xcfv_pkg::VERDICT_FRAMING_ERR;
        end else if (rx_sum != sum) begin
            o_result.verdict = xcfv_pkg::VERDICT_SUM_MISMATCH;
        end else if (n_cmd >= i_cfg.update_command_threshold) begin
            o_result.verdict = xcfv_pkg::VERDICT_UPDATE;
        end else if (len_x == EXT_W'(i_cfg.short_host_length)) begin
            o_result.verdict = xcfv_pkg::VERDICT_SHORT_HOST;
        end else if (len_x == EXT_W'(i_cfg.long_host_length)) begin
            o_result.verdict = xcfv_pkg::VERDICT_LONG_HOST;
        end else begin
            o_result.verdict = xcfv_pkg::VERDICT_UNKNOWN_HOST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_in.frame_end)) begin
            r_pos     <= '0;
            r_acc     <= '0;
            r_partial <= '0;
            r_hdr     <= 1'b0;
            r_cmd     <= '0;
            for (int k = 0; k < WD; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_advance) begin
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_partial <= n_partial;
            r_hdr     <= n_hdr;
            r_cmd     <= n_cmd;
            for (int k = 0; k < WD; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

endmodule

/* design/xor_checked_frame_validator.sv */
// ----------------------------------------------------------------------------
// xor_checked_frame_validator
// Checks framing and the word XOR checksum of received frames.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per transfer (i_valid / o_stall), with
// frame_end set on the last byte of a frame. One byte is taken every cycle
// while o_stall is low; in that cycle the trailer window shifts and the byte
// leaving it fills a partial word, XORed into the payload word once full.
// Output channel: one result per frame (o_valid / i_stall), presented in the
// cycle after the last byte is transferred, from a single output register.
// A held result does not block the input; o_stall rises only when a result
// is waiting and the receiver stalls, since the register cannot be freed.
// Configuration: write port i_cfg_valid / o_cfg_ready, always ready;
// index 0 header, 1 footer, 2 update threshold, 3 short host length,
// 4 long host length. Other indexes are dropped.
// Reset: synchronous, active low; clears frame state, drops any held result
// and loads the register defaults (0, 0, 0, 5, 256).
// ----------------------------------------------------------------------------
module xor_checked_frame_validator #(
    parameter int MAX_FRAME_BYTES = xcfv_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  xcfv_pkg::t_in_item                  i_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output xcfv_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [xcfv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [xcfv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    xcfv_pkg::t_cfg      r_cfg;
    xcfv_pkg::t_out_item r_out;
    xcfv_pkg::t_out_item core_result;
    logic                r_out_valid;
    logic                advance;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid & i_stall;
    assign advance     = i_valid & ~o_stall;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_value             <= xcfv_pkg::HEADER_RST;
            r_cfg.footer_value             <= xcfv_pkg::FOOTER_RST;
            r_cfg.update_command_threshold <= xcfv_pkg::UPDATE_THR_RST;
            r_cfg.short_host_length        <= xcfv_pkg::SHORT_LEN_RST;
            r_cfg.long_host_length         <= xcfv_pkg::LONG_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                xcfv_pkg::CFG_HEADER:     r_cfg.header_value <= i_cfg_data[7:0];
                xcfv_pkg::CFG_FOOTER:     r_cfg.footer_value <= i_cfg_data[7:0];
                xcfv_pkg::CFG_UPDATE_THR: r_cfg.update_command_threshold <= i_cfg_data[7:0];
                xcfv_pkg::CFG_SHORT_LEN:  r_cfg.short_host_length <= i_cfg_data[8:0];
                xcfv_pkg::CFG_LONG_LEN:   r_cfg.long_host_length <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    xcfv_frame_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_in      (i_in),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && i_in.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in.frame_end) begin
            r_out <= core_result;
        end
    end

endmodule

/* design/xcfv_checker.sv */
// ----------------------------------------------------------------------------
// xcfv_checker
// Port-level checks of the frame validator, bound to the top level.
// ----------------------------------------------------------------------------
module xcfv_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input xcfv_pkg::t_in_item              i_in,
    input logic                            o_valid,
    input logic                            i_stall,
    input xcfv_pkg::t_out_item             o_result
);

    a_hold_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    a_last_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_in.frame_end |=> o_valid && o_result.frame_length != 9'd0)
        else $error("no result after last byte");

    a_no_result_mid_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_in.frame_end |=> !o_valid)
        else $error("result without a last byte");

    a_verdict_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.verdict <= xcfv_pkg::VERDICT_SUM_MISMATCH)
        else $error("verdict code out of range");

    a_stall_needs_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with free output register");

endmodule

bind xor_checked_frame_validator xcfv_checker u_xcfv_checker (.*);
